[design/idp_pkg.sv]
package idp_pkg;

  // Datapath widths
  localparam int unsigned SUM_W      = 40;
  localparam int unsigned PROD_W     = 16;
  localparam int unsigned BIAS_W     = 32;
  localparam int unsigned RESULT_W   = 32;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned FMT_W      = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  // Default depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // Output saturation formats; the unused code falls back to s32
  typedef enum logic [FMT_W-1:0] {
    FMT_S32 = 2'd0,
    FMT_S8  = 2'd1,
    FMT_U8  = 2'd2
  } fmt_e;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SRC_SIGNED = 2'd0,
    CFG_BIAS_EN    = 2'd1,
    CFG_OUT_FMT    = 2'd2
  } cfg_idx_e;

  // One classified item as it travels from front to back
  typedef struct packed {
    logic signed [PROD_W-1:0] product;
    logic signed [BIAS_W-1:0] bias;
    logic [FMT_W-1:0]         fmt;
    logic                     last;
  } item_t;

endpackage

[design/idp_front.sv]
module idp_front (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [idp_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [idp_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [idp_pkg::BYTE_W-1:0]           source_byte_i,
  input  logic signed [idp_pkg::BYTE_W-1:0]    weight_value_i,
  input  logic signed [idp_pkg::BIAS_W-1:0]    bias_value_i,
  input  logic                                 last_element_i,
  input  logic                                 full_i,
  output logic                                 push_o,
  output idp_pkg::item_t                       push_item_o
);
  import idp_pkg::*;

  logic                     src_signed_q;
  logic                     bias_en_q;
  logic [FMT_W-1:0]         fmt_q;
  logic signed [BYTE_W:0]   src_ext;
  logic signed [2*BYTE_W:0] prod_full;

  // Configuration registers, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_signed_q <= 1'b1;
      bias_en_q    <= 1'b0;
      fmt_q        <= FMT_S32;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_SRC_SIGNED: src_signed_q <= cfg_data_i[0];
        CFG_BIAS_EN:    bias_en_q    <= cfg_data_i[0];
        CFG_OUT_FMT:    fmt_q        <= cfg_data_i[FMT_W-1:0];
        default:        ;
      endcase
    end
  end

  // Extend source per sign mode and form the product
  always_comb begin
    src_ext   = src_signed_q ? {source_byte_i[BYTE_W-1], source_byte_i}
                             : {1'b0, source_byte_i};
    prod_full = src_ext * weight_value_i;
  end

  // Classify the item and push it into the queue
  always_comb begin
    push_item_o.product = prod_full[PROD_W-1:0];
    push_item_o.bias    = bias_en_q ? bias_value_i : '0;
    push_item_o.fmt     = fmt_q;
    push_item_o.last    = last_element_i;
  end

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

endmodule

[design/idp_queue.sv]
module idp_queue #(
  parameter int unsigned DEPTH = idp_pkg::QUEUE_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  idp_pkg::item_t push_item_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output idp_pkg::item_t pop_item_o
);
  import idp_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  item_t             mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              do_push;
  logic              do_pop;

  assign full_o     = (count_q == CNT_W'(DEPTH));
  assign valid_o    = (count_q != '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;
  assign pop_item_o = mem_q[rd_ptr_q];

  // Advance pointers with wrap at the depth
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store item payload
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

[design/idp_back.sv]
module idp_back (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 valid_i,
  input  idp_pkg::item_t                       item_i,
  output logic                                 pop_o,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [idp_pkg::RESULT_W-1:0]  result_value_o
);
  import idp_pkg::*;

  localparam int unsigned TOT_W = SUM_W + 1;
  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
  localparam logic signed [TOT_W-1:0] S32_MIN = TOT_W'(-2147483647 - 1);
  localparam logic signed [TOT_W-1:0] S32_MAX = TOT_W'(2147483647);
  localparam logic signed [TOT_W-1:0] S8_MIN  = TOT_W'(-128);
  localparam logic signed [TOT_W-1:0] S8_MAX  = TOT_W'(127);
  localparam logic signed [TOT_W-1:0] U8_MIN  = TOT_W'(0);
  localparam logic signed [TOT_W-1:0] U8_MAX  = TOT_W'(255);

  logic signed [SUM_W-1:0]    sum_q, sum_d;
  logic signed [TOT_W-1:0]    acc_raw;
  logic signed [SUM_W-1:0]    acc_sat;

  logic                       fin_valid_q, fin_valid_d;
  logic signed [SUM_W-1:0]    fin_sum_q;
  logic signed [BIAS_W-1:0]   fin_bias_q;
  logic [FMT_W-1:0]           fin_fmt_q;

  logic                       out_valid_q, out_valid_d;
  logic signed [RESULT_W-1:0] out_value_q;

  logic signed [TOT_W-1:0]    total;
  logic signed [TOT_W-1:0]    lo, hi;
  logic signed [TOT_W-1:0]    clamped;

  logic                       out_free;
  logic                       fin_free;
  logic                       fin_load;

  // Stall control: a final sum needs a free slot, partial items never stall
  assign out_free = !out_valid_q || out_ready_i;
  assign fin_free = !fin_valid_q || out_free;
  assign pop_o    = valid_i && (!item_i.last || fin_free);
  assign fin_load = pop_o && item_i.last;

  // Accumulate with saturation at the sum bounds
  always_comb begin
    acc_raw = TOT_W'(sum_q) + TOT_W'(item_i.product);
    if (acc_raw[TOT_W-1] != acc_raw[TOT_W-2]) begin
      acc_sat = acc_raw[TOT_W-1] ? SUM_MIN : SUM_MAX;
    end else begin
      acc_sat = acc_raw[SUM_W-1:0];
    end
    sum_d = sum_q;
    if (pop_o) begin
      sum_d = item_i.last ? '0 : acc_sat;
    end
  end

  always_comb begin
    fin_valid_d = fin_valid_q;
    if (fin_load) begin
      fin_valid_d = 1'b1;
    end else if (out_free) begin
      fin_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q       <= '0;
      fin_valid_q <= 1'b0;
    end else begin
      sum_q       <= sum_d;
      fin_valid_q <= fin_valid_d;
    end
  end

  // Hold the finished sum with its bias and format
  always_ff @(posedge clk_i) begin
    if (fin_load) begin
      fin_sum_q  <= acc_sat;
      fin_bias_q <= item_i.bias;
      fin_fmt_q  <= item_i.fmt;
    end
  end

  // Add bias and saturate to the selected format
  always_comb begin
    total = TOT_W'(fin_sum_q) + TOT_W'(fin_bias_q);
    case (fin_fmt_q)
      FMT_S8: begin
        lo = S8_MIN;
        hi = S8_MAX;
      end
      FMT_U8: begin
        lo = U8_MIN;
        hi = U8_MAX;
      end
      default: begin
        lo = S32_MIN;
        hi = S32_MAX;
      end
    endcase
    if (total < lo) begin
      clamped = lo;
    end else if (total > hi) begin
      clamped = hi;
    end else begin
      clamped = total;
    end
  end

  // Output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (fin_valid_q && out_free) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_valid_q && out_free) begin
      out_value_q <= clamped[RESULT_W-1:0];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_value_o = out_value_q;

endmodule

[design/int8_dot_product_requantize.sv]
// Streaming int8 dot product with bias and saturating requantization.
// Throughput: one item per cycle while the queue is not full; a last item waits until the final sum slot is free.
// Result path: the item marked last passes the queue, the final sum register and the
// output register, with bias and saturation applied on the way into the output register.
// Reset: clears the running sum, queue and output valid; registers return to
// signed source, bias off, s32 output.
module int8_dot_product_requantize #(
  parameter int unsigned QUEUE_DEPTH = idp_pkg::QUEUE_DEPTH
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [idp_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [idp_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [idp_pkg::BYTE_W-1:0]           source_byte_i,
  input  logic signed [idp_pkg::BYTE_W-1:0]    weight_value_i,
  input  logic signed [idp_pkg::BIAS_W-1:0]    bias_value_i,
  input  logic                                 last_element_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [idp_pkg::RESULT_W-1:0]  result_value_o
);
  import idp_pkg::*;

  logic  push;
  item_t push_item;
  logic  full;
  logic  pop;
  logic  q_valid;
  item_t pop_item;

  // Front: config registers, product and classification
  idp_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .source_byte_i  (source_byte_i),
    .weight_value_i (weight_value_i),
    .bias_value_i   (bias_value_i),
    .last_element_i (last_element_i),
    .full_i         (full),
    .push_o         (push),
    .push_item_o    (push_item)
  );

  // Queue between front and back
  idp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .pop_item_o  (pop_item)
  );

  // Back: accumulate, bias, saturate, output register
  idp_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (q_valid),
    .item_i         (pop_item),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .result_value_o (result_value_o)
  );

endmodule

[tb/tb_int8_dot_product_requantize.sv]
module tb_int8_dot_product_requantize;
  timeunit 1ns;
  timeprecision 1ps;

  import idp_pkg::*;

  // Codes outside the defined sets, used to check that they are ignored or fall back
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;
  localparam logic [FMT_W-1:0]     FMT_UNUSED     = 2'd3;

  // Bounds of the wide running sum
  localparam longint SUM_HI = (longint'(1) <<< (SUM_W - 1)) - 1;
  localparam longint SUM_LO = -(longint'(1) <<< (SUM_W - 1));

  // Cycles to let pass once the stream has drained
  localparam int unsigned SETTLE_CYCLES = 8;

  typedef struct {
    logic [BYTE_W-1:0]        src;
    logic signed [BYTE_W-1:0] weight;
    logic signed [BIAS_W-1:0] bias;
    logic                     last;
    int unsigned              gap;
  } element_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                         cfg_valid_i = 1'b0;
  logic                         cfg_ready_o;
  logic [CFG_IDX_W-1:0]         cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]        cfg_data_i  = '0;
  logic                         in_valid_i  = 1'b0;
  logic                         in_ready_o;
  logic [BYTE_W-1:0]            source_byte_i  = '0;
  logic signed [BYTE_W-1:0]     weight_value_i = '0;
  logic signed [BIAS_W-1:0]     bias_value_i   = '0;
  logic                         last_element_i = 1'b0;
  logic                         out_valid_o;
  logic                         out_ready_i = 1'b0;
  logic signed [RESULT_W-1:0]   result_value_o;

  // Stimulus and prediction state
  element_t                   element_queue[$];
  logic signed [RESULT_W-1:0] due_results[$];
  int unsigned                gap_count;
  int unsigned                stall_left;
  int unsigned                fail_count = 0;
  bit                         steady_flow = 1'b0;

  // Mirror of the block's registers and running sum
  logic                       cfg_src_signed = 1'b1;
  logic                       cfg_bias_en    = 1'b0;
  logic [FMT_W-1:0]           cfg_fmt        = FMT_S32;
  longint                     dot_sum        = 0;

  int8_dot_product_requantize dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .source_byte_i  (source_byte_i),
    .weight_value_i (weight_value_i),
    .bias_value_i   (bias_value_i),
    .last_element_i (last_element_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .result_value_o (result_value_o)
  );

  always #2 clk_i = ~clk_i;

  function automatic longint limit_to(input longint v, input longint lo, input longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Accumulate one accepted item; on the last one, bias and saturate the total
  function automatic void accumulate_element(input logic [BYTE_W-1:0] src,
                                             input logic signed [BYTE_W-1:0] wt,
                                             input logic signed [BIAS_W-1:0] bias,
                                             input logic last);
    longint src_val;
    longint total;
    src_val = cfg_src_signed ? longint'($signed(src)) : longint'(src);
    dot_sum = limit_to(dot_sum + src_val * longint'(wt), SUM_LO, SUM_HI);
    if (last) begin
      total = dot_sum;
      if (cfg_bias_en) total = total + longint'(bias);
      case (cfg_fmt)
        FMT_S8:  total = limit_to(total, -128, 127);
        FMT_U8:  total = limit_to(total, 0, 255);
        default: total = limit_to(total, -64'sd2147483648, 64'sd2147483647);
      endcase
      due_results.push_back(total[RESULT_W-1:0]);
      dot_sum = 0;
    end
  endfunction

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("ERROR at %0t: %s", $realtime, msg);
  endtask

  // Compare one result item with the oldest expectation
  task automatic check_result(input logic signed [RESULT_W-1:0] got);
    logic signed [RESULT_W-1:0] want;
    if (due_results.size() == 0) begin
      note_failure($sformatf("result %0d with none expected", got));
    end else begin
      want = due_results.pop_front();
      if (got !== want)
        note_failure($sformatf("result_value expected %0d actual %0d", want, got));
    end
  endtask

  // Input side: hold until accepted, wait the item's gap, then present the next item
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      gap_count  <= 0;
    end else if (!(in_valid_i && !in_ready_o)) begin
      if (in_valid_i)
        accumulate_element(source_byte_i, weight_value_i, bias_value_i, last_element_i);
      if (element_queue.size() == 0) begin
        in_valid_i <= 1'b0;
      end else if (gap_count < element_queue[0].gap) begin
        in_valid_i <= 1'b0;
        gap_count  <= gap_count + 1;
      end else begin
        source_byte_i  <= element_queue[0].src;
        weight_value_i <= element_queue[0].weight;
        bias_value_i   <= element_queue[0].bias;
        last_element_i <= element_queue[0].last;
        in_valid_i     <= 1'b1;
        gap_count      <= 0;
        void'(element_queue.pop_front());
      end
    end
  end

  // Result side: check each accepted item, then stall for a random number of cycles unless the flow is steady
  always @(posedge clk_i) begin : result_side
    int unsigned hold;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_left  <= 0;
    end else if (out_valid_o && out_ready_i) begin
      check_result(result_value_o);
      hold = steady_flow ? 0 : $urandom_range(0, 10);
      stall_left  <= hold;
      out_ready_i <= (hold == 0);
    end else if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else begin
      stall_left  <= 0;
      out_ready_i <= 1'b1;
    end
  end

  function automatic logic [BYTE_W-1:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'h7F;
      2: return 8'h80;
      3: return 8'hFF;
      4: return BYTE_W'($urandom_range(0, 6));
      default: return BYTE_W'($urandom());
    endcase
  endfunction

  function automatic logic signed [BYTE_W-1:0] pick_weight();
    case ($urandom_range(0, 5))
      0: return -8'sd128;
      1: return 8'sd127;
      2, 3: return BYTE_W'($urandom_range(0, 6) - 3);
      default: return BYTE_W'($urandom());
    endcase
  endfunction

  function automatic logic signed [BIAS_W-1:0] pick_bias();
    case ($urandom_range(0, 7))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return 32'sd0;
      3, 4: return BIAS_W'(int'($urandom_range(0, 600)) - 300);
      default: return BIAS_W'($urandom());
    endcase
  endfunction

  task automatic add_element(input logic [BYTE_W-1:0] src, input logic signed [BYTE_W-1:0] wt,
                             input logic signed [BIAS_W-1:0] bias, input logic last);
    element_t e;
    e.src    = src;
    e.weight = wt;
    e.bias   = bias;
    e.last   = last;
    e.gap    = steady_flow ? 0 : $urandom_range(0, 10);
    element_queue.push_back(e);
  endtask

  // Wait until every queued item is taken and every result has come, then settle
  task automatic drain_stream();
    do @(posedge clk_i);
    while (element_queue.size() != 0 || in_valid_i || due_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write one register, with random upper data bits, and track it in the mirror
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [FMT_W-1:0] value);
    logic [CFG_DATA_W-1:0] word;
    word = $urandom();
    word[FMT_W-1:0] = value;
    if (idx != CFG_OUT_FMT) word[FMT_W-1] = word[CFG_DATA_W-1];
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= word;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_SRC_SIGNED: cfg_src_signed = word[0];
      CFG_BIAS_EN:    cfg_bias_en    = word[0];
      CFG_OUT_FMT:    cfg_fmt        = word[FMT_W-1:0];
      default: ;
    endcase
  endtask

  initial begin : stimulus
    int unsigned random_count;
    int unsigned phase_len;
    int unsigned n;
    int unsigned vec_len;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset setting: signed source, no bias, s32; extreme products and a short vector
    add_element(8'h80, -8'sd128, 32'sd0, 1'b1);
    add_element(8'h7F, 8'sd127, 32'sd0, 1'b1);
    add_element(8'h80, 8'sd127, 32'sd0, 1'b1);
    add_element(8'h00, 8'sd0, 32'sd0, 1'b1);
    add_element(8'hFF, -8'sd1, 32'sd0, 1'b0);
    add_element(8'h01, 8'sd1, 32'sd0, 1'b0);
    add_element(8'h7F, -8'sd128, 32'sd0, 1'b0);
    add_element(8'h80, 8'sd1, 32'sd0, 1'b1);
    drain_stream();

    // Bias on with the unused format code: saturate at both s32 bounds
    write_reg(CFG_BIAS_EN, 2'd1);
    write_reg(CFG_OUT_FMT, FMT_UNUSED);
    add_element(8'h7F, 8'sd127, 32'sh7FFF_FFFF, 1'b1);
    add_element(8'h80, 8'sd127, 32'sh8000_0000, 1'b1);
    add_element(8'h01, 8'sd1, -32'sd5, 1'b1);
    drain_stream();

    // s8 output: in range, above and below
    write_reg(CFG_OUT_FMT, FMT_S8);
    add_element(8'h05, 8'sd5, 32'sd100, 1'b1);
    add_element(8'h10, 8'sd16, 32'sd0, 1'b1);
    add_element(8'h80, 8'sd127, 32'sd0, 1'b1);
    add_element(8'h01, -8'sd1, -32'sd1, 1'b1);
    drain_stream();

    // Unsigned source with u8 output; leave a vector open across the next writes
    write_reg(CFG_SRC_SIGNED, 2'd0);
    write_reg(CFG_OUT_FMT, FMT_U8);
    add_element(8'hFF, 8'sd1, 32'sd0, 1'b1);
    add_element(8'hFF, 8'sd2, 32'sd0, 1'b1);
    add_element(8'hFF, -8'sd1, 32'sd0, 1'b1);
    add_element(8'h80, 8'sd1, 32'sh7FFF_FFFF, 1'b1);
    add_element(8'hFF, 8'sd127, 32'sd0, 1'b0);
    drain_stream();

    // Close the open vector under new settings; bias disabled, ignored index
    write_reg(CFG_SRC_SIGNED, 2'd1);
    write_reg(CFG_UNUSED_IDX, 2'd0);
    write_reg(CFG_BIAS_EN, 2'd0);
    write_reg(CFG_OUT_FMT, FMT_S32);
    add_element(8'hFF, 8'sd1, 32'sh7FFF_FFFF, 1'b1);
    drain_stream();

    // Random phases: new settings each phase, mostly short vectors
    random_count = 0;
    while (random_count < 650) begin
      write_reg(CFG_SRC_SIGNED, FMT_W'($urandom_range(0, 1)));
      write_reg(CFG_BIAS_EN, FMT_W'($urandom_range(0, 1)));
      write_reg(CFG_OUT_FMT, FMT_W'($urandom_range(0, 3)));
      if ($urandom_range(0, 4) == 0) write_reg(CFG_UNUSED_IDX, FMT_W'($urandom_range(0, 3)));
      steady_flow = ($urandom_range(0, 3) == 0);
      phase_len = $urandom_range(40, 120);
      n = 0;
      while (n < phase_len) begin
        vec_len = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 48) : $urandom_range(1, 8);
        for (int k = 0; k < vec_len; k++)
          add_element(pick_byte(), pick_weight(), pick_bias(), k == vec_len - 1);
        n += vec_len;
      end
      // Leave a partial vector open into the next phase now and then
      if ($urandom_range(0, 3) == 0) begin
        vec_len = $urandom_range(1, 3);
        for (int k = 0; k < vec_len; k++) add_element(pick_byte(), pick_weight(), pick_bias(), 1'b0);
        n += vec_len;
      end
      drain_stream();
      random_count += n;
    end

    // Long vector of largest products plus largest bias
    write_reg(CFG_SRC_SIGNED, 2'd1);
    write_reg(CFG_BIAS_EN, 2'd1);
    write_reg(CFG_OUT_FMT, FMT_S32);
    steady_flow = 1'b1;
    for (int k = 0; k < 512; k++) add_element(8'h80, -8'sd128, 32'sh7FFF_FFFF, k == 511);
    drain_stream();

    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Guard against a hang
  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
